>>> hw/rtl/cba_pkg.sv
`timescale 1ns / 1ps

package cba_pkg;

	localparam int BLOCKS = 2048;
	localparam int FILES  = 64;

	localparam int BLK_W  = $clog2(BLOCKS);
	localparam int CNT_W  = BLK_W + 1;
	localparam int ID_W   = $clog2(FILES);
	localparam int SIZE_W = 24;
	localparam int BS_W   = 17;
	localparam int STEP_W = $clog2(SIZE_W + 1);

	localparam logic [BS_W-1:0] BS_RESET = BS_W'(512);
	localparam logic [BS_W-1:0] BS_MAX   = BS_W'(65536);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [1:0] POL_FIRST   = 2'd0;
	localparam logic [1:0] POL_BEST    = 2'd1;
	localparam logic [1:0] POL_WORST   = 2'd2;
	localparam logic [1:0] POL_INVALID = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam int NUM_PRESET = 4;
	localparam int PRESET_BUSY [NUM_PRESET] = '{3, 6, 9, 17};

	typedef struct packed {
		logic             scan_go;
		logic [CNT_W-1:0] need;
		logic [1:0]       policy;
		logic             mark_go;
		logic [BLK_W-1:0] mark_start;
		logic [CNT_W-1:0] mark_count;
		logic             mark_value;
	} cba_map_cmd_t;

	typedef struct packed {
		logic             clearing;
		logic             scan_done;
		logic             found;
		logic [BLK_W-1:0] start;
		logic             mark_busy;
	} cba_map_sts_t;

	function automatic logic is_preset(input logic [BLK_W-1:0] addr);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_PRESET; k++) begin
			if (PRESET_BUSY[k] < BLOCKS && addr == BLK_W'(PRESET_BUSY[k]))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

>>> hw/rtl/cba_if.sv
`timescale 1ns / 1ps

interface cba_req_if;
	import cba_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ID_W-1:0]   file_id;
	logic [SIZE_W-1:0] file_size;
	logic [1:0]        fit_policy;
	modport source (output valid, mode, file_id, file_size, fit_policy, input ready);
	modport sink (input valid, mode, file_id, file_size, fit_policy, output ready);
endinterface

interface cba_rsp_if;
	import cba_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [BLK_W-1:0] start_block;
	logic [CNT_W-1:0] block_count;
	logic [BS_W-1:0]  last_free_bytes;
	modport source (output valid, status, start_block, block_count, last_free_bytes,
		input ready);
	modport sink (input valid, status, start_block, block_count, last_free_bytes,
		output ready);
endinterface

interface cba_cfg_if;
	import cba_pkg::*;
	logic            valid;
	logic            ready;
	logic [BS_W-1:0] block_bytes;
	modport source (output valid, block_bytes, input ready);
	modport sink (input valid, block_bytes, output ready);
endinterface

>>> hw/rtl/cba_div.sv
`timescale 1ns / 1ps

module cba_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cba_pkg::SIZE_W-1:0] dividend,
	input  logic [cba_pkg::BS_W-1:0]   divisor,
	output logic                       done,
	output logic [cba_pkg::SIZE_W-1:0] quot,
	output logic [cba_pkg::BS_W-1:0]   rem
);
	import cba_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SIZE_W-1:0] quot_q;
	logic [BS_W-1:0]   rem_q;
	logic [BS_W-1:0]   div_q;
	logic [BS_W:0]     trial;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quot_q[SIZE_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(SIZE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[SIZE_W-2:0], fits};
			if (fits)
				rem_q <= BS_W'(trial - {1'b0, div_q});
			else
				rem_q <= trial[BS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

>>> hw/rtl/cba_map.sv
`timescale 1ns / 1ps

module cba_map (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cba_pkg::cba_map_cmd_t cmd,
	output cba_pkg::cba_map_sts_t sts
);
	import cba_pkg::*;

	logic map_mem [BLOCKS];

	// clearing pass
	logic             clr_q;
	logic [BLK_W-1:0] clr_addr_q;

	// scan
	logic             scan_q;
	logic [BLK_W:0]   rd_addr_q;
	logic             rd_vld_s1;
	logic             rd_sent_s1;
	logic [BLK_W-1:0] idx_s1;
	logic             rd_data_s1;
	logic [CNT_W-1:0] run_len_q;
	logic [BLK_W-1:0] run_start_q;
	logic [CNT_W-1:0] best_len_q;
	logic [BLK_W-1:0] best_start_q;
	logic             found_q;
	logic             done_q;
	logic [CNT_W-1:0] need_q;
	logic [1:0]       pol_q;

	// mark
	logic [BLK_W:0]   mk_addr_q;
	logic [CNT_W-1:0] mk_left_q;
	logic             mk_val_q;

	logic             issue;
	logic             bit_free;
	logic             run_end;
	logic             fits;
	logic             take;
	logic             we;
	logic [BLK_W-1:0] wa;
	logic             wd;

	assign issue    = scan_q && (rd_addr_q <= (BLK_W+1)'(BLOCKS));
	assign bit_free = rd_vld_s1 && !rd_sent_s1 && rd_data_s1;
	assign run_end  = rd_vld_s1 && !bit_free && (run_len_q != '0);
	assign fits     = run_len_q >= need_q;

	always_comb begin
		case (pol_q)
			POL_FIRST: take = fits && !found_q;
			POL_BEST:  take = fits && (!found_q || run_len_q < best_len_q);
			default:   take = !found_q || run_len_q > best_len_q;
		endcase
	end

	assign we = clr_q || ((mk_left_q != '0) && (mk_addr_q < (BLK_W+1)'(BLOCKS)));
	assign wa = clr_q ? clr_addr_q : mk_addr_q[BLK_W-1:0];
	assign wd = clr_q ? !is_preset(clr_addr_q) : mk_val_q;

	always_ff @(posedge clk) begin
		if (we)
			map_mem[wa] <= wd;
		rd_data_s1 <= map_mem[rd_addr_q[BLK_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			scan_q     <= 1'b0;
			rd_addr_q  <= '0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
			mk_left_q  <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == BLK_W'(BLOCKS - 1))
					clr_q <= 1'b0;
			end

			rd_vld_s1 <= issue;
			done_q    <= 1'b0;
			if (cmd.scan_go) begin
				scan_q    <= 1'b1;
				rd_addr_q <= '0;
			end else begin
				if (issue)
					rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_vld_s1 && rd_sent_s1) begin
					scan_q <= 1'b0;
					done_q <= 1'b1;
				end
			end

			if (cmd.mark_go)
				mk_left_q <= cmd.mark_count;
			else if (mk_left_q != '0)
				mk_left_q <= mk_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_sent_s1 <= rd_addr_q == (BLK_W+1)'(BLOCKS);
		idx_s1     <= rd_addr_q[BLK_W-1:0];

		if (cmd.scan_go) begin
			need_q    <= cmd.need;
			pol_q     <= cmd.policy;
			found_q   <= 1'b0;
			run_len_q <= '0;
		end else if (rd_vld_s1) begin
			if (bit_free) begin
				if (run_len_q == '0)
					run_start_q <= idx_s1;
				run_len_q <= run_len_q + 1'b1;
			end else begin
				run_len_q <= '0;
				if (run_end && take) begin
					found_q      <= 1'b1;
					best_start_q <= run_start_q;
					best_len_q   <= run_len_q;
				end
			end
		end

		if (cmd.mark_go) begin
			mk_addr_q <= {1'b0, cmd.mark_start};
			mk_val_q  <= cmd.mark_value;
		end else if (mk_left_q != '0) begin
			mk_addr_q <= mk_addr_q + 1'b1;
		end
	end

	// worst fit may pick a run shorter than needed
	assign sts.clearing  = clr_q;
	assign sts.scan_done = done_q;
	assign sts.found     = found_q && (best_len_q >= need_q);
	assign sts.start     = best_start_q;
	assign sts.mark_busy = mk_left_q != '0;

endmodule

>>> hw/rtl/cba_ftab.sv
`timescale 1ns / 1ps

module cba_ftab (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cba_pkg::ID_W-1:0]  rd_id,
	output logic [cba_pkg::BLK_W-1:0] rd_start,
	output logic [cba_pkg::CNT_W-1:0] rd_len,
	input  logic                      we,
	input  logic [cba_pkg::ID_W-1:0]  wr_id,
	input  logic [cba_pkg::BLK_W-1:0] wr_start,
	input  logic [cba_pkg::CNT_W-1:0] wr_len
);
	import cba_pkg::*;

	logic [BLK_W+CNT_W-1:0] tab_mem [FILES];
	logic [FILES-1:0]       valid_q;
	logic [BLK_W+CNT_W-1:0] rd_data_s1;
	logic                   rd_vld_s1;

	always_ff @(posedge clk) begin
		if (we)
			tab_mem[wr_id] <= {wr_start, wr_len};
		rd_data_s1 <= tab_mem[rd_id];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (we)
				valid_q[wr_id] <= 1'b1;
			rd_vld_s1 <= valid_q[rd_id];
		end
	end

	assign rd_start = rd_vld_s1 ? rd_data_s1[BLK_W+CNT_W-1:CNT_W] : '0;
	assign rd_len   = rd_vld_s1 ? rd_data_s1[CNT_W-1:0] : '0;

endmodule

>>> hw/rtl/contiguous_block_allocator.sv
`timescale 1ns / 1ps

// Contiguous block allocator over a one-bit-per-block free map.
// req: one request per item (mode, file_id, file_size, fit_policy); ready is high only
//   while the block is idle, so one request is in work at a time.
// rsp: one result per request (status, start_block, block_count, last_free_bytes),
//   held in an output register until taken; the next request is accepted while it waits.
// cfg: block_bytes write, always ready; write only while no request is in work.
// Sequence: allocate reads the table entry, runs the serial divider, checks the size, scans
//   the map (one block per cycle through the map read port), then marks the run busy.
//   Free reads the table entry and releases its blocks. Invalid requests finish after the
//   table read.
// Reset: the free map is rebuilt by a clearing pass over all BLOCKS (2048) blocks, during
//   which req.ready stays low; the file table is empty and block_bytes is 512.
// A stalled receiver holds the result; a finished request then waits for the output
//   register before ready returns.
module contiguous_block_allocator (
	input logic        clk,
	input logic        arst_n,
	cba_req_if.sink    req,
	cba_rsp_if.source  rsp,
	cba_cfg_if.sink    cfg
);
	import cba_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TBL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_NEED = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_MARK = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]        state_q;
	logic [BS_W-1:0]   bs_cfg_q;
	logic [BS_W-1:0]   bs_eff;

	logic              mode_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic [1:0]        pol_q;
	logic [SIZE_W:0]   need_q;
	logic [BS_W-1:0]   lf_q;

	logic [1:0]        res_st_q;
	logic [BLK_W-1:0]  res_start_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [BS_W-1:0]   res_lf_q;

	logic              out_vld_q;
	logic [1:0]        out_st_q;
	logic [BLK_W-1:0]  out_start_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [BS_W-1:0]   out_lf_q;

	cba_map_cmd_t      map_cmd;
	cba_map_sts_t      map_sts;

	logic              div_go;
	logic              div_done;
	logic [SIZE_W-1:0] div_quot;
	logic [BS_W-1:0]   div_rem;

	logic [ID_W-1:0]   tab_rd_id;
	logic [BLK_W-1:0]  tab_start;
	logic [CNT_W-1:0]  tab_len;
	logic              tab_we;
	logic [BLK_W-1:0]  tab_wr_start;
	logic [CNT_W-1:0]  tab_wr_len;

	logic              req_acc;
	logic              rsp_acc;
	logic              load_out;
	logic              bad_req;
	logic              too_big;

	assign req.ready = (state_q == S_IDLE) && !map_sts.clearing;
	assign req_acc   = req.valid && req.ready;
	assign rsp_acc   = out_vld_q && rsp.ready;
	assign load_out  = (state_q == S_DONE) && (!out_vld_q || rsp.ready);
	assign cfg.ready = 1'b1;

	// table entry is read as the request is taken, so it is ready in S_TBL
	assign tab_rd_id = req_acc ? req.file_id : id_q;

	assign bad_req = (pol_q == POL_INVALID) || (size_q == '0);
	assign too_big = need_q > (SIZE_W+1)'(BLOCKS);

	always_comb begin
		if (bs_cfg_q == '0)
			bs_eff = BS_W'(1);
		else if (bs_cfg_q > BS_MAX)
			bs_eff = BS_MAX;
		else
			bs_eff = bs_cfg_q;
	end

	always_comb begin
		map_cmd      = '0;
		div_go       = 1'b0;
		tab_we       = 1'b0;
		tab_wr_start = '0;
		tab_wr_len   = '0;
		case (state_q)
			S_TBL: begin
				if (mode_q == MODE_FREE) begin
					map_cmd.mark_go    = 1'b1;
					map_cmd.mark_start = tab_start;
					map_cmd.mark_count = tab_len;
					map_cmd.mark_value = 1'b1;
					tab_we             = 1'b1;
				end else if (!bad_req) begin
					div_go = 1'b1;
				end
			end
			S_NEED: begin
				if (!too_big) begin
					map_cmd.scan_go = 1'b1;
					map_cmd.need    = need_q[CNT_W-1:0];
					map_cmd.policy  = pol_q;
				end
			end
			S_SCAN: begin
				if (map_sts.scan_done && map_sts.found) begin
					map_cmd.mark_go    = 1'b1;
					map_cmd.mark_start = map_sts.start;
					map_cmd.mark_count = need_q[CNT_W-1:0];
					map_cmd.mark_value = 1'b0;
					tab_we             = 1'b1;
					tab_wr_start       = map_sts.start;
					tab_wr_len         = need_q[CNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bs_cfg_q  <= BS_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				bs_cfg_q <= cfg.block_bytes;

			if (load_out)
				out_vld_q <= 1'b1;
			else if (rsp_acc)
				out_vld_q <= 1'b0;

			case (state_q)
				S_IDLE: if (req_acc) state_q <= S_TBL;
				S_TBL: begin
					if (mode_q == MODE_FREE)
						state_q <= S_MARK;
					else if (bad_req)
						state_q <= S_DONE;
					else
						state_q <= S_DIV;
				end
				S_DIV:  if (div_done) state_q <= S_NEED;
				S_NEED: state_q <= too_big ? S_DONE : S_SCAN;
				S_SCAN: begin
					if (map_sts.scan_done)
						state_q <= map_sts.found ? S_MARK : S_DONE;
				end
				S_MARK: if (!map_sts.mark_busy) state_q <= S_DONE;
				S_DONE: if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q <= req.mode;
			id_q   <= req.file_id;
			size_q <= req.file_size;
			pol_q  <= req.fit_policy;
		end

		if (state_q == S_DIV && div_done) begin
			need_q <= {1'b0, div_quot} + (SIZE_W+1)'(div_rem != '0);
			lf_q   <= (div_rem != '0) ? BS_W'(bs_eff - div_rem) : '0;
		end

		case (state_q)
			S_TBL: begin
				res_st_q    <= (mode_q == MODE_FREE) ? ST_OK : ST_INVALID;
				res_start_q <= (mode_q == MODE_FREE && tab_len != '0) ? tab_start : '0;
				res_cnt_q   <= (mode_q == MODE_FREE) ? tab_len : '0;
				res_lf_q    <= '0;
			end
			S_NEED: begin
				res_st_q    <= ST_NOSPACE;
				res_start_q <= '0;
				res_cnt_q   <= '0;
				res_lf_q    <= '0;
			end
			S_SCAN: begin
				if (map_sts.scan_done && map_sts.found) begin
					res_st_q    <= ST_OK;
					res_start_q <= map_sts.start;
					res_cnt_q   <= need_q[CNT_W-1:0];
					res_lf_q    <= lf_q;
				end
			end
			default: begin
			end
		endcase

		if (load_out) begin
			out_st_q    <= res_st_q;
			out_start_q <= res_start_q;
			out_cnt_q   <= res_cnt_q;
			out_lf_q    <= res_lf_q;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_st_q;
	assign rsp.start_block     = out_start_q;
	assign rsp.block_count     = out_cnt_q;
	assign rsp.last_free_bytes = out_lf_q;

	cba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (size_q),
		.divisor  (bs_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	cba_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.sts    (map_sts)
	);

	cba_ftab u_ftab (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_id    (tab_rd_id),
		.rd_start (tab_start),
		.rd_len   (tab_len),
		.we       (tab_we),
		.wr_id    (id_q),
		.wr_start (tab_wr_start),
		.wr_len   (tab_wr_len)
	);

endmodule

>>> hw/rtl/cba_chk.sv
`timescale 1ns / 1ps

module cba_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [1:0]                status,
	input logic [cba_pkg::BLK_W-1:0] start_block,
	input logic [cba_pkg::CNT_W-1:0] block_count,
	input logic [cba_pkg::BS_W-1:0]  last_free_bytes
);
	import cba_pkg::*;

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after an accepted request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_NOSPACE || status == ST_INVALID))
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |->
			start_block == '0 && block_count == '0 && last_free_bytes == '0)
		else $error("error result carries nonzero fields");

	a_run_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OK |->
			({1'b0, start_block} + {1'b0, block_count}) <= (CNT_W+1)'(BLOCKS))
		else $error("run extends past the last block");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(start_block)
			&& $stable(block_count) && $stable(last_free_bytes))
		else $error("stalled result changed");

endmodule

bind contiguous_block_allocator cba_chk u_cba_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.start_block     (rsp.start_block),
	.block_count     (rsp.block_count),
	.last_free_bytes (rsp.last_free_bytes)
);

>>> verif/contiguous_block_allocator_test.sv
`timescale 1ns / 1ps

module contiguous_block_allocator_test;
	import cba_pkg::*;

	localparam int LIMIT_CYCLES = 6_000_000;
	localparam int RANDOM_ITEMS = 280;
	localparam int NUM_PHASES   = 7;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   file_id;
		logic [SIZE_W-1:0] file_size;
		logic [1:0]        fit_policy;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] start_block;
		logic [CNT_W-1:0] block_count;
		logic [BS_W-1:0]  last_free_bytes;
	} alloc_result_t;

	class alloc_tracker;
		bit [BLOCKS-1:0]  free_map;
		int unsigned      run_start [FILES];
		int unsigned      run_len [FILES];
		logic [BS_W-1:0]  block_bytes;
		alloc_result_t    expected_results [$];
		int               errors;
		int               n_requests, n_placed, n_nospace, n_rejected, n_released, n_checked;

		function new();
			free_map = '1;
			for (int k = 0; k < NUM_PRESET; k++) begin
				if (PRESET_BUSY[k] < BLOCKS)
					free_map[PRESET_BUSY[k]] = 1'b0;
			end
			for (int f = 0; f < FILES; f++) begin
				run_start[f] = 0;
				run_len[f] = 0;
			end
			block_bytes = BS_RESET;
		endfunction

		function int unsigned eff_bytes();
			if (block_bytes == '0)
				return 1;
			if (block_bytes > BS_MAX)
				return BS_MAX;
			return block_bytes;
		endfunction

		function int unsigned count_free();
			return $countones(free_map);
		endfunction

		// Scans one past the end so the last run is closed too; ties keep the lowest start.
		function bit find_run(int unsigned need, logic [1:0] pol, output int unsigned where);
			bit          found;
			int unsigned best_start, best_len, rs, rl;
			found = 1'b0;
			best_start = 0;
			best_len = 0;
			rs = 0;
			rl = 0;
			where = 0;
			for (int i = 0; i <= BLOCKS; i++) begin
				if (i < BLOCKS && free_map[i]) begin
					if (rl == 0)
						rs = i;
					rl++;
				end else begin
					if (rl != 0) begin
						if (pol == POL_FIRST) begin
							if (rl >= need) begin
								where = rs;
								return 1'b1;
							end
						end else if (pol == POL_BEST) begin
							if (rl >= need && (!found || rl < best_len)) begin
								found = 1'b1;
								best_start = rs;
								best_len = rl;
							end
						end else if (!found || rl > best_len) begin
							found = 1'b1;
							best_start = rs;
							best_len = rl;
						end
					end
					rl = 0;
				end
			end
			if (!found || best_len < need)
				return 1'b0;
			where = best_start;
			return 1'b1;
		endfunction

		function void note_request(alloc_req_t r);
			alloc_result_t res;
			int unsigned   s, n, bs, need, rem, where;
			res = '0;
			n_requests++;
			if (r.mode == MODE_FREE) begin
				s = run_start[r.file_id];
				n = run_len[r.file_id];
				for (int unsigned i = 0; i < n; i++) begin
					if (s + i < BLOCKS)
						free_map[s + i] = 1'b1;
				end
				run_start[r.file_id] = 0;
				run_len[r.file_id] = 0;
				res.status = ST_OK;
				if (n != 0) begin
					res.start_block = BLK_W'(s);
					res.block_count = CNT_W'(n);
					n_released++;
				end
			end else if (r.fit_policy == POL_INVALID || r.file_size == '0) begin
				res.status = ST_INVALID;
				n_rejected++;
			end else begin
				bs = eff_bytes();
				need = r.file_size / bs;
				rem = r.file_size % bs;
				if (rem != 0)
					need++;
				if (need > BLOCKS || !find_run(need, r.fit_policy, where)) begin
					res.status = ST_NOSPACE;
					n_nospace++;
				end else begin
					for (int unsigned i = 0; i < need; i++)
						free_map[where + i] = 1'b0;
					// an occupied entry is simply overwritten; its old run leaks
					run_start[r.file_id] = where;
					run_len[r.file_id] = need;
					res.status = ST_OK;
					res.start_block = BLK_W'(where);
					res.block_count = CNT_W'(need);
					res.last_free_bytes = (rem != 0) ? BS_W'(bs - rem) : '0;
					n_placed++;
				end
			end
			expected_results.insert(expected_results.size(), res);
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			if (errors < 40)
				$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(alloc_result_t got);
			alloc_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", got.status, 0);
				return;
			end
			want = expected_results.pop_front();
			n_checked++;
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.start_block !== want.start_block)
				report_mismatch("start_block", got.start_block, want.start_block);
			if (got.block_count !== want.block_count)
				report_mismatch("block_count", got.block_count, want.block_count);
			if (got.last_free_bytes !== want.last_free_bytes)
				report_mismatch("last_free_bytes", got.last_free_bytes, want.last_free_bytes);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cba_req_if req ();
	cba_rsp_if rsp ();
	cba_cfg_if cfg ();

	contiguous_block_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	alloc_tracker    sb;
	int              burst_left;
	int unsigned     cycles_run;
	logic [BS_W-1:0] phase_bytes [NUM_PHASES];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run > LIMIT_CYCLES) begin
			$display("contiguous_block_allocator_test: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.status = rsp.status;
			got.start_block = rsp.start_block;
			got.block_count = rsp.block_count;
			got.last_free_bytes = rsp.last_free_bytes;
			sb.check_result(got);
		end
	end

	// receiver: long always-ready stretches mixed with short stall/run windows
	initial begin
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(50, 300)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// called in the step of a rising edge; valid stays high across a burst
	task automatic send_request(input alloc_req_t r);
		if (burst_left <= 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
		end
		req.valid <= 1'b1;
		req.mode <= r.mode;
		req.file_id <= r.file_id;
		req.file_size <= r.file_size;
		req.fit_policy <= r.fit_policy;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
		burst_left--;
	endtask

	task automatic issue(input logic mode, input int id, input int unsigned size,
		input logic [1:0] pol);
		alloc_req_t r;
		r.mode = mode;
		r.file_id = ID_W'(id);
		r.file_size = SIZE_W'(size);
		r.fit_policy = pol;
		send_request(r);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_block_bytes(input logic [BS_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.block_bytes <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.block_bytes = value;
	endtask

	function automatic int pick_entry(bit occupied);
		int first;
		first = $urandom_range(0, FILES - 1);
		for (int k = 0; k < FILES; k++) begin
			if ((sb.run_len[(first + k) % FILES] != 0) == occupied)
				return (first + k) % FILES;
		end
		return first;
	endfunction

	function automatic alloc_req_t pick_request();
		alloc_req_t  r;
		int unsigned bs, need, roll, span;
		bit          want_free;
		r.mode = MODE_ALLOC;
		r.file_id = ID_W'($urandom);
		r.file_size = SIZE_W'($urandom);
		r.fit_policy = 2'($urandom_range(0, 2));
		roll = $urandom_range(0, 99);
		want_free = (sb.count_free() < 300) ? (roll < 75) : (roll < 40);
		if (want_free) begin
			// size and policy are don't-care on free; leave them random
			r.mode = MODE_FREE;
			r.fit_policy = 2'($urandom);
			if ($urandom_range(0, 9) < 8)
				r.file_id = ID_W'(pick_entry(1'b1));
			return r;
		end
		if ($urandom_range(0, 99) < 85)
			r.file_id = ID_W'(pick_entry(1'b0));
		if ($urandom_range(0, 99) < 4)
			r.fit_policy = POL_INVALID;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			r.file_size = '0;
		end else if (roll >= 7) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				need = $urandom_range(1, 16);
			else if (roll < 92)
				need = $urandom_range(17, 200);
			else
				need = $urandom_range(201, 2100);
			bs = sb.eff_bytes();
			span = need * bs;
			if (span <= (1 << SIZE_W) - 1)
				r.file_size = SIZE_W'(span - $urandom_range(0, bs - 1));
		end
		return r;
	endfunction

	initial begin
		sb = new();
		cycles_run = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_ALLOC;
		req.file_id <= '0;
		req.file_size <= '0;
		req.fit_policy <= POL_FIRST;
		cfg.valid <= 1'b0;
		cfg.block_bytes <= BS_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset block size of 512
		issue(MODE_ALLOC, 0, 1, POL_FIRST);
		issue(MODE_ALLOC, 1, 1024, POL_FIRST);
		issue(MODE_ALLOC, 2, 700, POL_BEST);
		issue(MODE_ALLOC, 3, 300, POL_WORST);
		issue(MODE_ALLOC, 4, 0, POL_FIRST);
		issue(MODE_ALLOC, 5, 100, POL_INVALID);
		issue(MODE_FREE, 5, (1 << SIZE_W) - 1, POL_INVALID);
		issue(MODE_FREE, 1, 0, POL_FIRST);
		issue(MODE_ALLOC, 63, (1 << SIZE_W) - 1, POL_BEST);
		issue(MODE_ALLOC, 62, BLOCKS * 512, POL_FIRST);
		issue(MODE_ALLOC, 61, BLOCKS * 512, POL_WORST);
		issue(MODE_ALLOC, 60, 1000 * 512, POL_WORST);
		issue(MODE_ALLOC, 0, 1536, POL_FIRST);
		issue(MODE_FREE, 0, 0, POL_FIRST);
		issue(MODE_FREE, 60, 0, POL_FIRST);
		issue(MODE_ALLOC, 10, 2 * 512, POL_BEST);
		issue(MODE_FREE, 63, 0, POL_WORST);
		issue(MODE_ALLOC, 20, 1000 * 512 + 1, POL_FIRST);
		issue(MODE_FREE, 20, 0, POL_FIRST);
		issue(MODE_FREE, 2, 0, POL_FIRST);
		issue(MODE_FREE, 3, 0, POL_FIRST);
		issue(MODE_FREE, 10, 0, POL_FIRST);
		drain();

		// zero and over-range values exercise the clamp on both ends
		phase_bytes = '{17'd0, 17'd1, 17'd65536, 17'd131071, 17'd4096,
			17'($urandom_range(2, 65535)), 17'd512};
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_block_bytes(phase_bytes[p]);
			for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
				send_request(pick_request());
			drain();
		end

		$display("run covered %0d requests over %0d block sizes: %0d runs placed, %0d released",
			sb.n_requests, NUM_PHASES + 1, sb.n_placed, sb.n_released);
		$display("%0d refused for lack of space, %0d rejected as invalid, %0d results checked",
			sb.n_nospace, sb.n_rejected, sb.n_checked);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("contiguous_block_allocator_test: clean");
		else
			$display("contiguous_block_allocator_test: errors");
		$finish;
	end

endmodule
